FILE: src/weighted_graph_diameter_assert.svh
// Assertion macros for the weighted graph diameter block
`ifndef WEIGHTED_GRAPH_DIAMETER_ASSERT_SVH
`define WEIGHTED_GRAPH_DIAMETER_ASSERT_SVH

`define WGD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define WGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wgd_pkg.sv
// Shared types and constants for the weighted graph diameter block
`timescale 1ns / 1ps
`default_nettype none
package wgd_pkg;
    localparam int ID_W   = 6;
    localparam int WT_W   = 8;
    localparam int DIST_W = 14;
    localparam int CFG_W  = 7;
    localparam logic [CFG_W-1:0] NUM_RESET = 7'd64;

    typedef struct packed {
        logic [ID_W-1:0] src_node;
        logic [ID_W-1:0] dst_node;
        logic [WT_W-1:0] link_weight;
        logic            last_edge;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] diameter;
        logic              edges_overflowed;
        logic              bad_node_seen;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_INIT, ST_E_CHK, ST_E_WAIT, ST_RELAX,
        ST_SW_RD, ST_SW_CMP, ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic init;
        logic edge_rd;
        logic dist_rd;
        logic relax;
        logic pass_restart;
        logic sweep_start;
        logic sweep_rd;
        logic sweep_cmp;
        logic src_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic no_nodes;
        logic edge_end;
        logic changed;
        logic sweep_end;
        logic src_last;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

FILE: src/wgd_dp.sv
// Datapath: edge store, distance memory, counters and result register
`timescale 1ns / 1ps
`default_nettype none
module wgd_dp import wgd_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire t_in_item         i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output t_out_item             o_item
);
    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = 2 * ID_W + WT_W;

    logic [CFG_W-1:0]  r_num;
    logic [NCW-1:0]    w_n;
    logic [ECW-1:0]    r_count;
    logic              r_ovf, r_bad;
    logic [EDGE_W-1:0] r_edge_mem [MAX_EDGES];
    logic [EDGE_W-1:0] r_edge;
    logic [DIST_W-1:0] r_dist_mem [MAX_NODES];
    logic [DIST_W-1:0] r_da, r_db;
    logic              r_reached [MAX_NODES];
    logic              r_ra, r_rb;
    logic [ECW-1:0]    r_e;
    logic [NCW-1:0]    r_s, r_v;
    logic              r_changed;
    logic [DIST_W-1:0] r_diam;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [ID_W-1:0]   w_esrc, w_edst;
    logic [WT_W-1:0]   w_ewt;
    logic [NW-1:0]     w_addr_a, w_addr_b, w_waddr;
    logic [DIST_W-1:0] w_cand, w_wdata;
    logic              w_upd, w_we, w_bad;

    assign w_n = (32'(r_num) < MAX_NODES) ? NCW'(r_num) : NCW'(MAX_NODES);
    assign {w_esrc, w_edst, w_ewt} = r_edge;
    assign w_bad = (32'(i_item.src_node) >= 32'(w_n)) || (32'(i_item.dst_node) >= 32'(w_n));
    assign w_cand = r_da + DIST_W'(w_ewt);
    assign w_upd = i_cmd.relax && r_ra && (!r_rb || (w_cand < r_db));
    assign w_addr_a = i_cmd.sweep_rd ? r_v[NW-1:0] : NW'(w_esrc);
    assign w_addr_b = NW'(w_edst);
    assign w_we = w_upd || i_cmd.init;
    assign w_waddr = i_cmd.init ? r_s[NW-1:0] : NW'(w_edst);
    assign w_wdata = i_cmd.init ? '0 : w_cand;

    assign o_status.in_last   = i_item.last_edge;
    assign o_status.no_nodes  = (w_n == '0);
    assign o_status.edge_end  = (r_e == r_count);
    assign o_status.changed   = r_changed;
    assign o_status.sweep_end = (r_v == w_n);
    assign o_status.src_last  = (NCW'(r_s + NCW'(1)) == w_n);
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= NUM_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
            r_changed   <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) r_reached[i] <= 1'b0;
        end else begin
            if (i_cfg_we) r_num <= i_cfg_data;
            if (i_cmd.accept) begin
                if (w_bad) r_bad <= 1'b1;
                else if (r_count == ECW'(MAX_EDGES)) r_ovf <= 1'b1;
                else r_count <= r_count + ECW'(1);
            end
            if (i_cmd.out_load) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_bad       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.init) begin
                r_reached[r_s[NW-1:0]] <= 1'b1;
            end else if (w_upd) begin
                r_reached[NW'(w_edst)] <= 1'b1;
            end else if (i_cmd.sweep_cmp) begin
                r_reached[r_v[NW-1:0]] <= 1'b0;
            end
            if (i_cmd.init || i_cmd.pass_restart) r_changed <= 1'b0;
            else if (w_upd) r_changed <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !w_bad && (r_count != ECW'(MAX_EDGES))) begin
            r_edge_mem[r_count[EW-1:0]] <=
                {i_item.src_node, i_item.dst_node, i_item.link_weight};
        end
        if (i_cmd.edge_rd) r_edge <= r_edge_mem[r_e[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_dist_mem[w_waddr] <= w_wdata;
        if (i_cmd.dist_rd || i_cmd.sweep_rd) begin
            r_da <= r_dist_mem[w_addr_a];
            r_db <= r_dist_mem[w_addr_b];
            r_ra <= r_reached[w_addr_a];
            r_rb <= r_reached[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_s    <= '0;
            r_diam <= '0;
        end
        if (i_cmd.src_next) r_s <= r_s + NCW'(1);
        if (i_cmd.init || i_cmd.pass_restart) r_e <= '0;
        if (i_cmd.relax) r_e <= r_e + ECW'(1);
        if (i_cmd.sweep_start) r_v <= '0;
        if (i_cmd.sweep_cmp) begin
            r_v <= r_v + NCW'(1);
            if (r_ra && (r_da > r_diam)) r_diam <= r_da;
        end
        if (i_cmd.out_load) begin
            r_out.diameter         <= r_diam;
            r_out.edges_overflowed <= r_ovf;
            r_out.bad_node_seen    <= r_bad;
        end
    end
endmodule
`default_nettype wire

FILE: src/wgd_ctrl.sv
// Controller: sequences loading, relaxation passes, sweeps and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module wgd_ctrl import wgd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && i_status.in_last) n_state = ST_START;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state = i_status.no_nodes ? ST_OUT : ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state = ST_E_CHK;
            end
            ST_E_CHK: begin
                if (!i_status.edge_end) begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = ST_E_WAIT;
                end else if (i_status.changed) begin
                    o_cmd.pass_restart = 1'b1;
                end else begin
                    o_cmd.sweep_start = 1'b1;
                    n_state = ST_SW_RD;
                end
            end
            ST_E_WAIT: begin
                o_cmd.dist_rd = 1'b1;
                n_state = ST_RELAX;
            end
            ST_RELAX: begin
                o_cmd.relax = 1'b1;
                n_state = ST_E_CHK;
            end
            ST_SW_RD: begin
                if (!i_status.sweep_end) begin
                    o_cmd.sweep_rd = 1'b1;
                    n_state = ST_SW_CMP;
                end else if (i_status.src_last) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.src_next = 1'b1;
                    n_state = ST_INIT;
                end
            end
            ST_SW_CMP: begin
                o_cmd.sweep_cmp = 1'b1;
                n_state = ST_SW_RD;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/weighted_graph_diameter.sv
// Top level of the weighted graph diameter block
// Links load one item per cycle into the edge store. An item with last_edge
// set starts the all-pairs search: for each source node, Bellman-Ford passes
// walk the edge store one edge at a time (edge read, distance read, relax) until a
// pass changes nothing, then a sweep over the nodes finds the farthest
// reached node and clears the reached bits. A source takes at most n passes.
// Input is stalled meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module weighted_graph_diameter import wgd_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_in_item         i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_out_item             o_item,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    wgd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    wgd_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

`include "weighted_graph_diameter_assert.svh"

    `WGD_ASSERT_NEXT(a_last_stalls, w_cmd.accept && i_item.last_edge, !o_ready, "no stall")
    `WGD_ASSERT_NEXT(a_out_load, w_cmd.out_load, o_valid, "result load did not raise valid")
    `WGD_ASSERT_SAME(a_no_work_idle, o_ready, !w_cmd.relax, "search active while loading")
endmodule
`default_nettype wire
